@@ rtl/core/scancode_set1_to_ascii_decoder_assert.svh @@
// Assertion macros for the scan-code decoder.
// Used by the front-end and top-level modules; no other dependencies.
`ifndef SCANCODE_SET1_TO_ASCII_DECODER_ASSERT_SVH
`define SCANCODE_SET1_TO_ASCII_DECODER_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define SC_ASSERT_IMP(lbl, clk, rstn, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (c)) \
    else $error("assertion failed");
// Implication with the consequent checked in the next cycle.
`define SC_ASSERT_NEXT(lbl, clk, rstn, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (c)) \
    else $error("assertion failed");
`endif

@@ rtl/core/sc1a_pkg.sv @@
// Shared types, command codes and AZERTY tables of the scan-code decoder.
// No dependencies.
`default_nettype none
package sc1a_pkg;
  localparam logic [7:0] CMD_NONE = 8'hFF;
  localparam logic [7:0] CMD_PAUSE = 8'h0D;
  localparam logic [7:0] CMD_PRINT = 8'h0F;
  localparam logic [7:0] CMD_TAB = 8'h10;
  localparam logic [7:0] CMD_CAPS = 8'h11;
  localparam logic [7:0] CMD_SHIFTL = 8'h12;
  localparam logic [7:0] CMD_CTRLL = 8'h13;
  localparam logic [7:0] CMD_ALTL = 8'h14;
  localparam logic [7:0] CMD_WINL = 8'h15;
  localparam logic [7:0] CMD_SHIFTR = 8'h16;
  localparam logic [7:0] CMD_CTRLR = 8'h17;
  localparam logic [7:0] CMD_ALTR = 8'h18;
  localparam logic [7:0] CMD_MENU = 8'h19;
  localparam logic [7:0] CMD_ENTER = 8'h1A;
  localparam logic [7:0] CMD_BACK = 8'h1B;
  localparam logic [7:0] CMD_WINR = 8'h27;
  localparam logic [7:0] CMD_PADENTER = 8'h28;

  localparam logic [7:0] B_E0 = 8'hE0;
  localparam logic [7:0] B_E1 = 8'hE1;
  localparam logic [7:0] B_F0 = 8'hF0;

  // Sequence shape handed from the front end to the back end.
  typedef enum logic [2:0] {
    K_PLAIN, K_EXT, K_REL, K_PAUSE, K_PRINT_P, K_PRINT_R, K_E1_OTHER, K_ERR
  } seq_kind_e;

  typedef struct packed {
    seq_kind_e  kind;
    logic [7:0] key;
  } seq_t;

  function automatic logic [7:0] lower_map(input logic [6:0] k);
    case (k)
      7'h02: lower_map = 8'd38;  7'h03: lower_map = 8'd130; 7'h04: lower_map = 8'd34;
      7'h05: lower_map = 8'd39;  7'h06: lower_map = 8'd40;  7'h07: lower_map = 8'd45;
      7'h08: lower_map = 8'd138; 7'h09: lower_map = 8'd95;  7'h0A: lower_map = 8'd135;
      7'h0B: lower_map = 8'd133; 7'h0C: lower_map = 8'd41;  7'h0D: lower_map = 8'd61;
      7'h10: lower_map = "a"; 7'h11: lower_map = "z"; 7'h12: lower_map = "e";
      7'h13: lower_map = "r"; 7'h14: lower_map = "t"; 7'h15: lower_map = "y";
      7'h16: lower_map = "u"; 7'h17: lower_map = "i"; 7'h18: lower_map = "o";
      7'h19: lower_map = "p"; 7'h1A: lower_map = "^"; 7'h1B: lower_map = "$";
      7'h1E: lower_map = "q"; 7'h1F: lower_map = "s"; 7'h20: lower_map = "d";
      7'h21: lower_map = "f"; 7'h22: lower_map = "g"; 7'h23: lower_map = "h";
      7'h24: lower_map = "j"; 7'h25: lower_map = "k"; 7'h26: lower_map = "l";
      7'h27: lower_map = "m"; 7'h28: lower_map = 8'd151; 7'h29: lower_map = 8'd253;
      7'h2B: lower_map = "*"; 7'h2C: lower_map = "w"; 7'h2D: lower_map = "x";
      7'h2E: lower_map = "c"; 7'h2F: lower_map = "v"; 7'h30: lower_map = "b";
      7'h31: lower_map = "n"; 7'h32: lower_map = ","; 7'h33: lower_map = ";";
      7'h34: lower_map = ":"; 7'h35: lower_map = "!"; 7'h37: lower_map = "*";
      7'h39: lower_map = " "; 7'h47: lower_map = "7"; 7'h48: lower_map = "8";
      7'h49: lower_map = "9"; 7'h4A: lower_map = "-"; 7'h4B: lower_map = "4";
      7'h4C: lower_map = "5"; 7'h4D: lower_map = "6"; 7'h4E: lower_map = "+";
      7'h4F: lower_map = "1"; 7'h50: lower_map = "2"; 7'h51: lower_map = "3";
      7'h52: lower_map = "0"; 7'h53: lower_map = "."; 7'h56: lower_map = "<";
      default: lower_map = 8'd0;
    endcase
  endfunction

  function automatic logic [7:0] upper_map(input logic [6:0] k);
    case (k)
      7'h02: upper_map = "1"; 7'h03: upper_map = "2"; 7'h04: upper_map = "3";
      7'h05: upper_map = "4"; 7'h06: upper_map = "5"; 7'h07: upper_map = "6";
      7'h08: upper_map = "7"; 7'h09: upper_map = "8"; 7'h0A: upper_map = "9";
      7'h0B: upper_map = "0"; 7'h0C: upper_map = 8'd248; 7'h0D: upper_map = "+";
      7'h10: upper_map = "A"; 7'h11: upper_map = "Z"; 7'h12: upper_map = "E";
      7'h13: upper_map = "R"; 7'h14: upper_map = "T"; 7'h15: upper_map = "Y";
      7'h16: upper_map = "U"; 7'h17: upper_map = "I"; 7'h18: upper_map = "O";
      7'h19: upper_map = "P"; 7'h1A: upper_map = 8'hA8; 7'h1B: upper_map = 8'd156;
      7'h1E: upper_map = "Q"; 7'h1F: upper_map = "S"; 7'h20: upper_map = "D";
      7'h21: upper_map = "F"; 7'h22: upper_map = "G"; 7'h23: upper_map = "H";
      7'h24: upper_map = "J"; 7'h25: upper_map = "K"; 7'h26: upper_map = "L";
      7'h27: upper_map = "M"; 7'h28: upper_map = "%"; 7'h29: upper_map = 8'd253;
      7'h2B: upper_map = 8'hB5; 7'h2C: upper_map = "W"; 7'h2D: upper_map = "X";
      7'h2E: upper_map = "C"; 7'h2F: upper_map = "V"; 7'h30: upper_map = "B";
      7'h31: upper_map = "N"; 7'h32: upper_map = "?"; 7'h33: upper_map = ".";
      7'h34: upper_map = "/"; 7'h35: upper_map = 8'hA7; 7'h37: upper_map = "*";
      7'h39: upper_map = " "; 7'h47: upper_map = "7"; 7'h48: upper_map = "8";
      7'h49: upper_map = "9"; 7'h4A: upper_map = "-"; 7'h4B: upper_map = "4";
      7'h4C: upper_map = "5"; 7'h4D: upper_map = "6"; 7'h4E: upper_map = "+";
      7'h4F: upper_map = "1"; 7'h50: upper_map = "2"; 7'h51: upper_map = "3";
      7'h52: upper_map = "0"; 7'h53: upper_map = "."; 7'h56: upper_map = ">";
      default: upper_map = 8'd0;
    endcase
  endfunction

  function automatic logic [7:0] plain_cmd(input logic [6:0] k);
    case (k)
      7'h01: plain_cmd = 8'hF8;
      7'h0E: plain_cmd = CMD_BACK;
      7'h0F: plain_cmd = CMD_TAB;
      7'h1C: plain_cmd = CMD_ENTER;
      7'h1D: plain_cmd = CMD_CTRLL;
      7'h2A: plain_cmd = CMD_SHIFTL;
      7'h36: plain_cmd = CMD_SHIFTR;
      7'h38: plain_cmd = CMD_ALTL;
      7'h3A: plain_cmd = CMD_CAPS;
      7'h3B: plain_cmd = 8'h01; 7'h3C: plain_cmd = 8'h02; 7'h3D: plain_cmd = 8'h03;
      7'h3E: plain_cmd = 8'h04; 7'h3F: plain_cmd = 8'h05; 7'h40: plain_cmd = 8'h06;
      7'h41: plain_cmd = 8'h07; 7'h42: plain_cmd = 8'h08; 7'h43: plain_cmd = 8'h09;
      7'h44: plain_cmd = 8'h0A; 7'h45: plain_cmd = 8'h26; 7'h46: plain_cmd = 8'h0E;
      7'h57: plain_cmd = 8'h0B; 7'h58: plain_cmd = 8'h0C;
      default: plain_cmd = 8'h00;
    endcase
  endfunction

  function automatic logic [7:0] ext_plain(input logic [6:0] k);
    case (k)
      7'h1C: ext_plain = CMD_PADENTER;
      7'h1D: ext_plain = CMD_CTRLR;
      7'h38: ext_plain = CMD_ALTR;
      7'h47: ext_plain = 8'h1D;
      7'h48: ext_plain = 8'h22;
      7'h49: ext_plain = 8'h1E;
      7'h4B: ext_plain = 8'h23;
      7'h4D: ext_plain = 8'h24;
      7'h4F: ext_plain = 8'h20;
      7'h50: ext_plain = 8'h25;
      7'h51: ext_plain = 8'h21;
      7'h52: ext_plain = 8'h1C;
      7'h53: ext_plain = 8'h1F;
      7'h5B: ext_plain = CMD_WINL;
      7'h5C: ext_plain = CMD_WINR;
      7'h5D: ext_plain = CMD_MENU;
      default: ext_plain = 8'h00;
    endcase
  endfunction
endpackage
`default_nettype wire

@@ rtl/core/sc1a_front.sv @@
// Front end: assembles scan-code bytes into sequences and classifies them.
// Depends on sc1a_pkg and the assertion macro header.
`default_nettype none
`include "scancode_set1_to_ascii_decoder_assert.svh"
module sc1a_front import sc1a_pkg::*; #(
  parameter int unsigned MaxSeqLen = 6
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       valid_i,
  input  wire logic [7:0] byte_i,
  output logic            done_o,
  output seq_t            seq_o
);
  localparam int unsigned CntW = $clog2(MaxSeqLen + 1);

  logic [CntW-1:0] cnt_q, cnt_d;
  logic [7:0] b0_q, b0_d, b1_q, b1_d, b2_q, b2_d;
  logic [7:0] b0, b1, b2;

  // The bytes of the sequence as they stand after this byte.
  always_comb begin
    b0 = (cnt_q == '0) ? byte_i : b0_q;
    b1 = (cnt_q == CntW'(1)) ? byte_i : b1_q;
    b2 = (cnt_q == CntW'(2)) ? byte_i : b2_q;
  end

  // Decide whether the sequence stays open, and how a closed one decodes.
  always_comb begin
    done_o = 1'b0;
    cnt_d = cnt_q;
    b0_d = b0;
    b1_d = b1;
    b2_d = b2;
    seq_o.kind = K_PLAIN;
    seq_o.key = b0;
    if (valid_i) begin
      if (b0 == B_E1) begin
        if (cnt_q == CntW'(5)) begin
          done_o = 1'b1;
          seq_o.kind = (b1 == 8'h1D && b2 == 8'h45) ? K_PAUSE : K_E1_OTHER;
        end
      end else if (cnt_q == CntW'(1) && b0 == B_E0 && (b1 == 8'h2A || b1 == 8'hB7)) begin
        // Print-screen form keeps going.
      end else if (byte_i == B_E0 || byte_i == B_F0) begin
        if (cnt_q == CntW'(MaxSeqLen - 1)) begin
          done_o = 1'b1;
          seq_o.kind = K_ERR;
        end
      end else begin
        done_o = 1'b1;
        if (cnt_q == CntW'(3) && b0 == B_E0 && b1 == 8'h2A && b2 == B_E0 && byte_i == 8'h37)
          seq_o.kind = K_PRINT_P;
        else if (cnt_q == CntW'(3) && b0 == B_E0 && b1 == 8'hB7 && b2 == B_E0
                 && byte_i == 8'hAA)
          seq_o.kind = K_PRINT_R;
        else if (b0 == B_F0) begin
          seq_o.kind = K_REL;
          seq_o.key = b1;
        end else if (b0 == B_E0) begin
          seq_o.kind = K_EXT;
          seq_o.key = b1;
        end
      end
      if (done_o) begin
        cnt_d = '0;
        b0_d = '0;
        b1_d = '0;
        b2_d = '0;
      end else begin
        cnt_d = cnt_q + CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      b0_q <= '0;
      b1_q <= '0;
      b2_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      b0_q <= b0_d;
      b1_q <= b1_d;
      b2_q <= b2_d;
    end
  end

  `SC_ASSERT_IMP(a_cnt_range, clk_i, rst_ni, 1'b1, cnt_q < CntW'(MaxSeqLen))
  `SC_ASSERT_NEXT(a_done_clears, clk_i, rst_ni, done_o, cnt_q == '0)
  `SC_ASSERT_NEXT(a_open_counts, clk_i, rst_ni, valid_i && !done_o,
                  cnt_q == $past(cnt_q) + CntW'(1))
endmodule
`default_nettype wire

@@ rtl/core/sc1a_back.sv @@
// Back end: turns a classified sequence into command, character and flags.
// Depends on sc1a_pkg.
`default_nettype none
module sc1a_back import sc1a_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       valid_i,
  input  seq_t            seq_i,
  output logic [7:0]      cmd_o,
  output logic            chv_o,
  output logic [7:0]      ch_o,
  output logic            err_o,
  output logic [9:0]      flags_o
);
  logic [9:0] flags_q, flags_d;
  logic [7:0] cmd;
  logic pressed, ctrl, shift, upper, hold;
  logic [3:0] bitn;
  logic [6:0] k;

  assign k = seq_i.key[6:0];
  assign ctrl = |flags_q[3:2];
  assign shift = |flags_q[1:0];

  // Command lookup and hold-flag update.
  always_comb begin
    cmd = 8'h00;
    pressed = 1'b1;
    case (seq_i.kind)
      K_PAUSE: cmd = CMD_PAUSE;
      K_PRINT_P: cmd = CMD_PRINT;
      K_PRINT_R: begin cmd = CMD_PRINT; pressed = 1'b0; end
      K_REL: begin cmd = plain_cmd(k); pressed = 1'b0; end
      K_EXT: begin
        cmd = ext_plain(k);
        hold = cmd == CMD_CTRLR || cmd == CMD_ALTR || cmd == CMD_WINL ||
               cmd == CMD_WINR || cmd == CMD_MENU;
        if (!hold && (ctrl || shift)) begin
          case (k)
            7'h48: cmd = ctrl ? 8'h29 : 8'h33;
            7'h50: cmd = ctrl ? 8'h30 : 8'h34;
            7'h4B: cmd = ctrl ? 8'h31 : 8'h35;
            7'h4D: cmd = ctrl ? 8'h32 : 8'h36;
            default: cmd = 8'h00;
          endcase
        end
        pressed = !seq_i.key[7];
      end
      K_E1_OTHER: cmd = CMD_NONE;
      default: begin cmd = plain_cmd(k); pressed = !seq_i.key[7]; end
    endcase
    hold = 1'b0;
    bitn = 4'd0;
    case (cmd)
      CMD_SHIFTL: begin bitn = 4'd0; hold = 1'b1; end
      CMD_SHIFTR: begin bitn = 4'd1; hold = 1'b1; end
      CMD_CTRLL: begin bitn = 4'd2; hold = 1'b1; end
      CMD_CTRLR: begin bitn = 4'd3; hold = 1'b1; end
      CMD_ALTL: begin bitn = 4'd4; hold = 1'b1; end
      CMD_ALTR: begin bitn = 4'd5; hold = 1'b1; end
      CMD_WINL: begin bitn = 4'd6; hold = 1'b1; end
      CMD_WINR: begin bitn = 4'd7; hold = 1'b1; end
      CMD_MENU: begin bitn = 4'd8; hold = 1'b1; end
      CMD_CAPS: begin bitn = 4'd9; hold = 1'b1; end
      default: ;
    endcase
    flags_d = flags_q;
    if (seq_i.kind != K_ERR && hold) begin
      if (cmd == CMD_CAPS) flags_d[9] = flags_q[9] ^ pressed;
      else flags_d[bitn] = pressed;
    end
  end

  // Result assembly.
  always_comb begin
    upper = shift ^ flags_q[9];
    err_o = seq_i.kind == K_ERR;
    cmd_o = (err_o || hold || !pressed) ? CMD_NONE : cmd;
    chv_o = 1'b1;
    ch_o = 8'h00;
    if (err_o) chv_o = 1'b0;
    else if (cmd_o == CMD_ENTER || cmd_o == CMD_PADENTER) ch_o = 8'h0A;
    else if (cmd_o == CMD_BACK) ch_o = 8'h08;
    else if (cmd_o == CMD_TAB) ch_o = 8'h09;
    else begin
      chv_o = 1'b0;
      if (cmd_o == 8'h00 && !ctrl) begin
        if (seq_i.kind == K_PLAIN && !seq_i.key[7])
          ch_o = upper ? upper_map(k) : lower_map(k);
        else if (seq_i.kind == K_EXT && !seq_i.key[7] && k == 7'h35)
          ch_o = "/";
        chv_o = ch_o != 8'h00;
      end
    end
    flags_o = flags_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) flags_q <= '0;
    else if (valid_i) flags_q <= flags_d;
  end
endmodule
`default_nettype wire

@@ rtl/core/scancode_set1_to_ascii_decoder.sv @@
// Top level of the set-1 scan-code to AZERTY decoder.
// Depends on sc1a_pkg, sc1a_front, sc1a_back and the assertion header.
//
// One scan byte is taken each cycle while the two-entry sequence queue
// between the front end and the back end has room. The front end closes a
// sequence in the cycle of its last byte and queues its shape. The back end
// decodes the head of the queue, so a result is offered once its sequence
// is registered at the queue head. Bytes may follow back to back with no gap.
// When the receiver stalls, two closed sequences wait in the queue before
// the input is held off.
`default_nettype none
`include "scancode_set1_to_ascii_decoder_assert.svh"
module scancode_set1_to_ascii_decoder import sc1a_pkg::*; #(
  parameter int unsigned MAX_SEQ_LEN = 6
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [7:0] scan_byte_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [7:0]      key_command_o,
  output logic            char_valid_o,
  output logic [7:0]      char_code_o,
  output logic            seq_error_o,
  output logic [9:0]      modifier_flags_o
);
  logic acc, done;
  seq_t seq, q0_q, q1_q;
  logic [1:0] n_q, n_d;
  logic push, pop;

  assign in_ready_o = n_q != 2'd2;
  assign acc = in_valid_i && in_ready_o;

  sc1a_front #(.MaxSeqLen(MAX_SEQ_LEN)) u_front (
    .clk_i, .rst_ni, .valid_i(acc), .byte_i(scan_byte_i), .done_o(done), .seq_o(seq)
  );

  // Two-entry sequence queue; entry 0 is the head.
  assign push = done;
  assign pop = out_valid_o && out_ready_i;
  assign n_d = n_q + {1'b0, push} - {1'b0, pop};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) n_q <= '0;
    else n_q <= n_d;
  end

  always_ff @(posedge clk_i) begin
    if (pop) q0_q <= (n_q == 2'd2) ? q1_q : seq;
    else if (push && n_q == 2'd0) q0_q <= seq;
    if (push && ((n_q == 2'd1 && !pop) || n_q == 2'd2)) q1_q <= seq;
  end

  assign out_valid_o = n_q != 2'd0;

  // The back end decodes the head item and commits its flags when it leaves.
  sc1a_back u_back (
    .clk_i, .rst_ni, .valid_i(pop), .seq_i(q0_q),
    .cmd_o(key_command_o), .chv_o(char_valid_o), .ch_o(char_code_o),
    .err_o(seq_error_o), .flags_o(modifier_flags_o)
  );

  `SC_ASSERT_IMP(a_no_overflow, clk_i, rst_ni, n_q == 2'd2, !done)
  `SC_ASSERT_IMP(a_cnt_max, clk_i, rst_ni, 1'b1, n_q != 2'd3)
  `SC_ASSERT_NEXT(a_hold_out, clk_i, rst_ni, out_valid_o && !out_ready_i,
                  out_valid_o && $stable(q0_q))
endmodule
`default_nettype wire
